// File: sv/pdd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdd_pkg;

	localparam int MAX_POINTS  = 256;
	localparam int COORD_WIDTH = 16;
	localparam int TOL_W       = 36;
	localparam int KEPT_W      = 9;

	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int WORD_W = 3 * COORD_WIDTH;
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int SUM_W  = SQ_W + 2;
	localparam int CMP_W  = (SUM_W > TOL_W) ? SUM_W : TOL_W;

	typedef enum logic [1:0] {
		ST_ACCEPT = 2'd0,
		ST_DUP    = 2'd1,
		ST_FULL   = 2'd2,
		ST_CLEAR  = 2'd3
	} status_t;

	typedef enum logic {
		KIND_OFFER = 1'b0,
		KIND_CLEAR = 1'b1
	} kind_t;

	typedef struct packed {
		logic    load;
		logic    issue;
		logic    finish;
		status_t code;
	} ctrl_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_full;
		logic scan_last;
		logic pipe_busy;
		logic near_any;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: sv/pdd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pdd_ctrl import pdd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      kind,
	input  wire dp_stat_t  stat,
	output ctrl_cmd_t      cmd,
	output logic           busy,
	output logic           done
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_DRAIN = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.issue  = 1'b0;
		cmd.finish = 1'b0;
		cmd.code   = ST_ACCEPT;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (kind == KIND_CLEAR) begin
						cmd.finish = 1'b1;
						cmd.code   = ST_CLEAR;
					end else if (stat.count_full) begin
						cmd.finish = 1'b1;
						cmd.code   = ST_FULL;
					end else if (stat.count_zero) begin
						state_d = S_DRAIN;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (stat.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!stat.pipe_busy) begin
					cmd.finish = 1'b1;
					cmd.code   = stat.near_any ? ST_DUP : ST_ACCEPT;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire

// File: sv/pdd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pdd_datapath import pdd_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ctrl_cmd_t                     cmd,
	input  wire logic signed [COORD_WIDTH-1:0] coord_x,
	input  wire logic signed [COORD_WIDTH-1:0] coord_y,
	input  wire logic signed [COORD_WIDTH-1:0] coord_z,
	input  wire logic                          cfg_valid,
	input  wire logic [TOL_W-1:0]              cfg_data,
	output dp_stat_t                           stat,
	output status_t                            status,
	output logic [KEPT_W-1:0]                  kept_count
);

	logic [WORD_W-1:0] mem [MAX_POINTS];

	logic [TOL_W-1:0]              tol_q;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              scan_q;
	logic                          near_q;
	status_t                       status_q;
	logic signed [COORD_WIDTH-1:0] px_q, py_q, pz_q;

	logic                          v_s1, v_s2, v_s3;
	logic [WORD_W-1:0]             rd_s1;
	logic signed [DIFF_W-1:0]      dx_s2, dy_s2, dz_s2;
	logic [SQ_W-1:0]               sqx_s3, sqy_s3, sqz_s3;

	logic signed [COORD_WIDTH-1:0] mx, my, mz;
	logic signed [DIFF_W-1:0]      dx, dy, dz;
	logic signed [SQ_W-1:0]        px2, py2, pz2;
	logic [SUM_W-1:0]              sum;
	logic                          near_now;

	// stored word is {z, y, x}
	assign mx = rd_s1[COORD_WIDTH-1:0];
	assign my = rd_s1[2*COORD_WIDTH-1:COORD_WIDTH];
	assign mz = rd_s1[3*COORD_WIDTH-1:2*COORD_WIDTH];

	always_comb begin
		dx  = {px_q[COORD_WIDTH-1], px_q} - {mx[COORD_WIDTH-1], mx};
		dy  = {py_q[COORD_WIDTH-1], py_q} - {my[COORD_WIDTH-1], my};
		dz  = {pz_q[COORD_WIDTH-1], pz_q} - {mz[COORD_WIDTH-1], mz};
		px2 = dx_s2 * dx_s2;
		py2 = dy_s2 * dy_s2;
		pz2 = dz_s2 * dz_s2;
		sum = SUM_W'(sqx_s3) + SUM_W'(sqy_s3) + SUM_W'(sqz_s3);
		near_now = (CMP_W'(sum) <= CMP_W'(tol_q));
	end

	// point store
	always_ff @(posedge clk) begin
		if (cmd.finish && cmd.code == ST_ACCEPT) begin
			mem[count_q[ADDR_W-1:0]] <= {pz_q, py_q, px_q};
		end
		if (cmd.issue) begin
			rd_s1 <= mem[scan_q[ADDR_W-1:0]];
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= coord_x;
			py_q <= coord_y;
			pz_q <= coord_z;
		end
		dx_s2  <= dx;
		dy_s2  <= dy;
		dz_s2  <= dz;
		sqx_s3 <= unsigned'(px2);
		sqy_s3 <= unsigned'(py2);
		sqz_s3 <= unsigned'(pz2);
		if (cmd.finish) begin
			status_q <= cmd.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= '0;
			count_q <= '0;
			scan_q  <= '0;
			near_q  <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				tol_q <= cfg_data;
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.load) begin
				scan_q <= '0;
				near_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					scan_q <= scan_q + CNT_W'(1);
				end
				if (v_s3 && near_now) begin
					near_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				if (cmd.code == ST_CLEAR) begin
					count_q <= '0;
				end else if (cmd.code == ST_ACCEPT) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	assign stat.count_zero = (count_q == '0);
	assign stat.count_full = (count_q == CNT_W'(MAX_POINTS));
	assign stat.scan_last  = (scan_q == count_q - CNT_W'(1));
	assign stat.pipe_busy  = v_s1 | v_s2 | v_s3;
	assign stat.near_any   = near_q;

	assign status     = status_q;
	assign kept_count = KEPT_W'(count_q);

endmodule

`default_nettype wire

// File: sv/point_distance_dedup_unit.sv
// channel   signals                               transfer when
// -------   -----------------------------------   ------------------------
// item      start, busy, kind, coord_x/y/z        start high and busy low
// result    done, status, kept_count              done high (one cycle)
// config    cfg_valid, cfg_ready, cfg_data        cfg_valid and cfg_ready
//
// an offer against n kept points finishes after all n kept points have been read:
// one memory read per cycle into a compare pipeline (read, diff, square, sum)
// an offer into an empty store finishes in the cycle after the transfer, a clear or
// an offer into a full store at the transfer edge itself
// done rises the cycle after finishing and busy is already low in that cycle
// reset empties the store, zeroes the tolerance; cfg_ready stays high, results never stall
`timescale 1ns / 1ps
`default_nettype none

module point_distance_dedup_unit import pdd_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          kind,
	input  wire logic signed [COORD_WIDTH-1:0] coord_x,
	input  wire logic signed [COORD_WIDTH-1:0] coord_y,
	input  wire logic signed [COORD_WIDTH-1:0] coord_z,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [KEPT_W-1:0]                  kept_count,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [TOL_W-1:0]              cfg_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	status_t   status_w;

	pdd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pdd_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.stat       (stat),
		.status     (status_w),
		.kept_count (kept_count)
	);

	assign status    = status_w;
	assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// File: verif/point_distance_dedup_unit_tb.sv
`timescale 1ns / 1ps

module point_distance_dedup_unit_tb;
	import pdd_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int HIST_DEPTH  = 32;
	localparam logic [TOL_W-1:0] TOL_MAX = {TOL_W{1'b1}};

	typedef enum logic {ROW_ITEM, ROW_TOL} row_op_t;
	typedef enum int {GEN_NEAR, GEN_REPEAT, GEN_EXTREME, GEN_CLUSTER, GEN_UNIFORM} gen_mode_t;

	typedef struct {
		row_op_t                       op;
		kind_t                         k;
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
		logic [TOL_W-1:0]              tol;
		logic                          typed;
		status_t                       st;
		logic [KEPT_W-1:0]             cnt;
	} dir_row_t;

	typedef struct packed {
		status_t           st;
		logic [KEPT_W-1:0] cnt;
	} outcome_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
	} point_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic                          kind = 1'b0;
	logic signed [COORD_WIDTH-1:0] coord_x = '0;
	logic signed [COORD_WIDTH-1:0] coord_y = '0;
	logic signed [COORD_WIDTH-1:0] coord_z = '0;
	logic                          done;
	logic [1:0]                    status;
	logic [KEPT_W-1:0]             kept_count;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [TOL_W-1:0]              cfg_data = '0;

	// typed expectation travels with the item
	logic              row_typed = 1'b0;
	status_t           row_status = ST_ACCEPT;
	logic [KEPT_W-1:0] row_count = '0;

	logic signed [COORD_WIDTH-1:0] kept_x [MAX_POINTS];
	logic signed [COORD_WIDTH-1:0] kept_y [MAX_POINTS];
	logic signed [COORD_WIDTH-1:0] kept_z [MAX_POINTS];
	int                            kept_num = 0;
	logic [TOL_W-1:0]              tol_sq = '0;

	outcome_t outcomes_due[$];
	point_t   sent_hist[$];
	dir_row_t dir_rows[$];

	int mismatches = 0;
	int cycles = 0;
	int n_items = 0;
	int n_tol = 0;
	int n_accept = 0;
	int n_dup = 0;
	int n_full = 0;
	int n_clear = 0;

	point_distance_dedup_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.done(done),
		.status(status),
		.kept_count(kept_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic outcome_t dedup_decide(input logic k,
			input logic signed [COORD_WIDTH-1:0] x, y, z);
		outcome_t o;
		bit       near;
		longint   dx, dy, dz;
		near = 1'b0;
		if (k == KIND_CLEAR) begin
			kept_num = 0;
			o.st = ST_CLEAR;
		end else if (kept_num >= MAX_POINTS) begin
			o.st = ST_FULL;
		end else begin
			for (int i = 0; i < kept_num && !near; i++) begin
				dx = longint'(x) - longint'(kept_x[i]);
				dy = longint'(y) - longint'(kept_y[i]);
				dz = longint'(z) - longint'(kept_z[i]);
				if (dx * dx + dy * dy + dz * dz <= longint'(tol_sq))
					near = 1'b1;
			end
			if (near) begin
				o.st = ST_DUP;
			end else begin
				kept_x[kept_num] = x;
				kept_y[kept_num] = y;
				kept_z[kept_num] = z;
				kept_num++;
				o.st = ST_ACCEPT;
			end
		end
		o.cnt = KEPT_W'(kept_num);
		return o;
	endfunction

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		outcome_t o;
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d outcomes pending", cycles,
				outcomes_due.size());
			$display("FAILURE");
			$finish;
		end
		if (arst_n) begin
			if (done) begin
				if (outcomes_due.size() == 0) begin
					report($sformatf("result with nothing pending (status %0d, count %0d)",
						status, kept_count));
				end else begin
					o = outcomes_due.pop_front();
					if (status !== o.st)
						report($sformatf("status got %0d expected %0d", status, o.st));
					if (kept_count !== o.cnt)
						report($sformatf("kept_count got %0d expected %0d", kept_count, o.cnt));
					case (o.st)
						ST_ACCEPT: n_accept++;
						ST_DUP:    n_dup++;
						ST_FULL:   n_full++;
						default:   n_clear++;
					endcase
				end
			end
			if (cfg_valid && cfg_ready) begin
				tol_sq = cfg_data;
				n_tol++;
			end
			// item transfer: predict and queue the outcome
			if (start && !busy) begin
				o = dedup_decide(kind, coord_x, coord_y, coord_z);
				if (row_typed) begin
					o.st = row_status;
					o.cnt = row_count;
				end
				outcomes_due.insert(outcomes_due.size(), o);
				n_items++;
			end
		end
	end

	task automatic send_item(input kind_t k, input logic signed [COORD_WIDTH-1:0] x, y, z,
			input logic typed, input status_t st, input logic [KEPT_W-1:0] cnt);
		start <= 1'b1;
		kind <= k;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		row_typed <= typed;
		row_status <= st;
		row_count <= cnt;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (outcomes_due.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_tol(input logic [TOL_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_item(input kind_t k, input int x, y, z,
			input logic typed, input status_t st, input int cnt);
		dir_row_t r;
		r.op = ROW_ITEM;
		r.k = k;
		r.x = x[COORD_WIDTH-1:0];
		r.y = y[COORD_WIDTH-1:0];
		r.z = z[COORD_WIDTH-1:0];
		r.tol = '0;
		r.typed = typed;
		r.st = st;
		r.cnt = cnt[KEPT_W-1:0];
		dir_rows.insert(dir_rows.size(), r);
	endtask

	task automatic add_tol(input logic [TOL_W-1:0] v);
		dir_row_t r;
		r.op = ROW_TOL;
		r.k = KIND_OFFER;
		r.x = '0;
		r.y = '0;
		r.z = '0;
		r.tol = v;
		r.typed = 1'b0;
		r.st = ST_ACCEPT;
		r.cnt = '0;
		dir_rows.insert(dir_rows.size(), r);
	endtask

	function automatic logic [TOL_W-1:0] random_tol();
		logic [63:0] w;
		w = {$urandom, $urandom} >> $urandom_range(63, 28);
		return w[TOL_W-1:0];
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] pick_coord(input gen_mode_t mode,
			input int base_c, input int rad, input int spread);
		int v, lim;
		case (mode)
			GEN_NEAR: begin
				lim = rad * 3 / 4 + 1;
				v = base_c + int'($urandom_range(2 * lim)) - lim;
			end
			GEN_REPEAT: v = base_c;
			GEN_EXTREME: begin
				case ($urandom_range(4))
					0: v = -32768;
					1: v = -1;
					2: v = 0;
					3: v = 1;
					default: v = 32767;
				endcase
			end
			GEN_CLUSTER: v = int'($urandom_range(2 * spread)) - spread;
			default: v = int'($urandom_range(65535)) - 32768;
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[COORD_WIDTH-1:0];
	endfunction

	task automatic run_phase(input logic [TOL_W-1:0] tol, input int n, input int clear_pct,
			input int spread, input int near_pct, input int idle_pct);
		int        rad, sel, gap;
		gen_mode_t mode;
		kind_t     k;
		point_t    base, p;
		drain();
		write_tol(tol);
		rad = int'($sqrt(real'(tol)));
		if (rad > 40000)
			rad = 40000;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(99) < clear_pct) ? KIND_CLEAR : KIND_OFFER;
			sel = $urandom_range(99);
			if (sel < near_pct)
				mode = GEN_NEAR;
			else if (sel < near_pct + 5)
				mode = GEN_REPEAT;
			else if (sel < near_pct + 10)
				mode = GEN_EXTREME;
			else if (sel < near_pct + 30)
				mode = GEN_CLUSTER;
			else
				mode = GEN_UNIFORM;
			if ((mode == GEN_NEAR || mode == GEN_REPEAT) && sent_hist.size() == 0)
				mode = GEN_CLUSTER;
			base = '0;
			if (sent_hist.size() != 0)
				base = sent_hist[$urandom_range(sent_hist.size() - 1)];
			p.x = pick_coord(mode, base.x, rad, spread);
			p.y = pick_coord(mode, base.y, rad, spread);
			p.z = pick_coord(mode, base.z, rad, spread);
			if (k == KIND_OFFER) begin
				sent_hist.insert(sent_hist.size(), p);
				if (sent_hist.size() > HIST_DEPTH)
					void'(sent_hist.pop_front());
			end
			send_item(k, p.x, p.y, p.z, 1'b0, ST_ACCEPT, '0);
			if ($urandom_range(99) < idle_pct) begin
				gap = ($urandom_range(7) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 4);
				idle(gap);
			end
			if ($urandom_range(49) == 0)
				drain();
		end
	endtask

	initial begin
		add_item(KIND_CLEAR, 32767, -32768, 21845, 1'b1, ST_CLEAR, 0);
		add_item(KIND_OFFER, 0, 0, 0, 1'b1, ST_ACCEPT, 1);
		add_item(KIND_OFFER, 0, 0, 0, 1'b1, ST_DUP, 1);
		add_item(KIND_OFFER, 0, 0, 1, 1'b0, ST_ACCEPT, 0);
		add_item(KIND_OFFER, -32768, -32768, -32768, 1'b0, ST_ACCEPT, 0);
		add_item(KIND_OFFER, 32767, 32767, 32767, 1'b0, ST_ACCEPT, 0);
		add_item(KIND_OFFER, 32767, -32768, 32767, 1'b0, ST_ACCEPT, 0);
		add_item(KIND_OFFER, -1, -1, -1, 1'b0, ST_ACCEPT, 0);
		add_tol(36'd100);
		add_item(KIND_OFFER, 10, 0, 0, 1'b0, ST_ACCEPT, 0);
		add_item(KIND_OFFER, 0, -11, 0, 1'b0, ST_ACCEPT, 0);
		add_item(KIND_OFFER, 6, 8, 0, 1'b0, ST_ACCEPT, 0);
		add_item(KIND_OFFER, -32768, -32767, -32768, 1'b0, ST_ACCEPT, 0);
		add_tol(TOL_MAX);
		add_item(KIND_OFFER, -32768, 32767, -32768, 1'b0, ST_ACCEPT, 0);
		add_item(KIND_CLEAR, -1, -1, -1, 1'b1, ST_CLEAR, 0);
		add_item(KIND_OFFER, -32768, 32767, -32768, 1'b1, ST_ACCEPT, 1);
		add_item(KIND_OFFER, 32767, -32768, 32767, 1'b0, ST_ACCEPT, 0);
		add_tol('0);
		add_item(KIND_CLEAR, 0, 0, 0, 1'b1, ST_CLEAR, 0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].op == ROW_TOL) begin
				drain();
				write_tol(dir_rows[i].tol);
			end else begin
				send_item(dir_rows[i].k, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
					dir_rows[i].typed, dir_rows[i].st, dir_rows[i].cnt);
			end
		end

		// sender gaps after 8 of 100 items
		run_phase('0, 300, 0, 32767, 5, 8);
		run_phase(36'd400, 220, 4, 60, 40, 8);
		// sender gaps after 45 of 100 items
		run_phase(TOL_MAX, 90, 10, 32767, 20, 45);
		run_phase(random_tol(), 110, 5, 2000, 40, 45);
		run_phase(random_tol(), 110, 5, 2000, 40, 45);
		// back to back
		run_phase(36'd1, 160, 4, 2, 30, 0);
		run_phase('0, 290, 0, 32767, 5, 0);

		drain();
		repeat (300) @(posedge clk);
		$display("covered %0d items under %0d tolerance settings: %0d accepted, %0d near dups",
			n_items, n_tol, n_accept, n_dup);
		$display("%0d offers refused on a full store, %0d clears, %0d mismatches",
			n_full, n_clear, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
